>>> rtl/oal_pkg.sv
// Package for the offset array list: field widths, request codes, status codes
// and configuration register indexes.
// No dependencies; used by rtl/offset_array_list.sv.
`default_nettype none

package oal_pkg;

    // Field widths of the request and result transfers.
    localparam int ACTION_W   = 3;
    localparam int POS_W      = 8;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // Default store depth.
    localparam int DEPTH_DEFAULT = 256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 1'd1;

    // Register values after reset.
    localparam logic [CFG_DATA_W-1:0] BASE_OFFSET_RESET = 9'd0;
    localparam logic [CFG_DATA_W-1:0] CAPACITY_RESET    = 9'd256;

    // Request codes.
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_INSERT     = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_REMOVE     = 3'd7;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOFRONT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOBACK  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

endpackage

`default_nettype wire

>>> rtl/offset_array_list.sv
// Offset array list: a contiguous list in a single-port-read, single-port-write
// element memory, with start and count registers and a shift sequencer.
// Depends on rtl/oal_pkg.sv.
//
// Usage: requests arrive on the in_valid/in_ready channel (action, position,
// data_in); each request gives exactly one result on out_valid/out_ready
// (read_data, status, occupied, first_position). One request is worked on at
// a time: a new request is taken only once the last result has gone to the
// output register. Insert and remove move the affected elements one per cycle
// through the memory (one read and one write each cycle, pipelined by the read
// latency); an insert then writes the new value at the requested position.
// The number moved is at most the list length, 255 at the default depth.
// A finished result sits in the output register; the next request is taken
// while it waits. When the receiver stalls with a result still waiting, the
// block finishes the next request and then holds it until the output frees.
// Reset empties the list, clears base_offset to 0 and capacity to 256; the
// element memory is not cleared. A write to either configuration register
// also empties the list and puts its start at the base offset, capped at the capacity.
`default_nettype none

module offset_array_list #(
    parameter int DEPTH = oal_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Configuration writes.
    input  wire logic                                   cfg_write,
    input  wire logic [oal_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire logic [oal_pkg::CFG_DATA_W-1:0]         cfg_data,
    // Request channel.
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic [oal_pkg::ACTION_W-1:0]           action,
    input  wire logic [oal_pkg::POS_W-1:0]              position,
    input  wire logic signed [oal_pkg::DATA_W-1:0]      data_in,
    // Result channel.
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [oal_pkg::DATA_W-1:0]           read_data,
    output logic [oal_pkg::STATUS_W-1:0]                status,
    output logic [oal_pkg::COUNT_W-1:0]                 occupied,
    output logic [oal_pkg::COUNT_W-1:0]                 first_position
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = oal_pkg::COUNT_W;
    localparam int DW      = oal_pkg::DATA_W;
    localparam int CAP_LIM = (DEPTH > (2 ** CW) - 1) ? (2 ** CW) - 1 : DEPTH;
    localparam logic [CW-1:0] CAP_LIM_V = CAP_LIM[CW-1:0];

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_FILL   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    // Maps a list position onto a memory address.
    function automatic logic [AW-1:0] to_addr(input logic [CW-1:0] a);
        logic [AW+CW-1:0] wide;
        wide = {{AW{1'b0}}, a};
        return wide[AW-1:0];
    endfunction

    // Element memory and its registered read data.
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic          mem_we;
    logic [CW-1:0] mem_waddr;
    logic [DW-1:0] mem_wdata;
    logic          mem_re;
    logic [CW-1:0] mem_raddr;

    // Control state.
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] cap_reg, cap_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] left_reg, left_next;
    logic          down_reg, down_next;
    logic          fill_reg, fill_next;
    logic          pend_reg, pend_next;
    logic [CW-1:0] pend_dst_reg, pend_dst_next;
    logic [oal_pkg::STATUS_W-1:0] st_reg, st_next;
    logic          rd_ok_reg, rd_ok_next;
    logic          out_valid_reg, out_valid_next;

    // Latched request.
    logic [oal_pkg::ACTION_W-1:0] act_reg;
    logic [oal_pkg::POS_W-1:0]    pos_reg;
    logic [DW-1:0]                din_reg;

    // Result register.
    logic [DW-1:0]                read_data_reg;
    logic [oal_pkg::STATUS_W-1:0] status_reg;
    logic [CW-1:0]                occupied_reg;
    logic [CW-1:0]                first_reg;

    // Decode helpers.
    logic [CW:0]   end_w;
    logic [CW-1:0] pos9;
    logic          pos_ok;
    logic          room_back;
    logic          full;
    logic          in_xfer;
    logic          out_load;
    logic [CW-1:0] cfg_cap_eff;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign end_w     = {1'b0, start_reg} + {1'b0, count_reg};
    assign pos9      = {1'b0, pos_reg};
    assign pos_ok    = (pos9 < cap_reg) && (pos9 >= start_reg) && ({1'b0, pos9} < end_w);
    assign room_back = end_w < {1'b0, cap_reg};
    assign full      = count_reg >= cap_reg;

    assign cfg_cap_eff = (cfg_data > CAP_LIM_V) ? CAP_LIM_V : cfg_data;

    // Sequencer, list bookkeeping and memory control.
    always_comb
    begin
        state_next     = state_reg;
        start_next     = start_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        cap_next       = cap_reg;
        src_next       = src_reg;
        left_next      = left_reg;
        down_next      = down_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        pend_dst_next  = pend_dst_reg;
        st_next        = st_reg;
        rd_ok_next     = rd_ok_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos9;
        mem_wdata      = din_reg;
        mem_re         = 1'b0;
        mem_raddr      = pos9;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                st_next    = oal_pkg::ST_OK;
                rd_ok_next = 1'b0;
                fill_next  = 1'b0;
                pend_next  = 1'b0;
                state_next = S_DONE;
                unique case (act_reg)
                    oal_pkg::ACT_READ:
                    begin
                        if (pos_ok)
                        begin
                            mem_re     = 1'b1;
                            rd_ok_next = 1'b1;
                        end
                        else
                        begin
                            st_next = oal_pkg::ST_BADPOS;
                        end
                    end
                    oal_pkg::ACT_WRITE:
                    begin
                        if (pos_ok)
                        begin
                            mem_we = 1'b1;
                        end
                        else
                        begin
                            st_next = oal_pkg::ST_BADPOS;
                        end
                    end
                    oal_pkg::ACT_PUSH_FRONT:
                    begin
                        if (full)
                        begin
                            st_next = oal_pkg::ST_FULL;
                        end
                        else if (start_reg == '0)
                        begin
                            st_next = oal_pkg::ST_NOFRONT;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = start_reg - 1'b1;
                            start_next = start_reg - 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    oal_pkg::ACT_POP_FRONT:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = oal_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            start_next = start_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    oal_pkg::ACT_PUSH_BACK:
                    begin
                        if (full)
                        begin
                            st_next = oal_pkg::ST_FULL;
                        end
                        else if (room_back)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = end_w[CW-1:0];
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            st_next = oal_pkg::ST_NOBACK;
                        end
                    end
                    oal_pkg::ACT_POP_BACK:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = oal_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    oal_pkg::ACT_INSERT:
                    begin
                        if (full)
                        begin
                            st_next = oal_pkg::ST_FULL;
                        end
                        else if (!pos_ok)
                        begin
                            st_next = oal_pkg::ST_BADPOS;
                        end
                        else if (room_back)
                        begin
                            // Move the tail from position onward one place right.
                            src_next   = end_w[CW-1:0] - 1'b1;
                            left_next  = end_w[CW-1:0] - pos9;
                            down_next  = 1'b1;
                            fill_next  = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            // Move the head up to position one place left.
                            src_next   = start_reg;
                            left_next  = pos9 - start_reg + 1'b1;
                            down_next  = 1'b0;
                            fill_next  = 1'b1;
                            count_next = count_reg + 1'b1;
                            start_next = start_reg - 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                    oal_pkg::ACT_REMOVE:
                    begin
                        if (!pos_ok)
                        begin
                            st_next = oal_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            // Move the elements after position one place left.
                            src_next   = pos9 + 1'b1;
                            left_next  = end_w[CW-1:0] - pos9 - 1'b1;
                            down_next  = 1'b0;
                            count_next = count_reg - 1'b1;
                            state_next = S_SHIFT;
                        end
                    end
                endcase
            end
            S_SHIFT:
            begin
                // Write back the element read in the previous cycle.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_dst_reg;
                    mem_wdata = rdata_reg;
                end
                // Read the next element, or finish once all have been read.
                if (left_reg != '0)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = src_reg;
                    left_next     = left_reg - 1'b1;
                    pend_next     = 1'b1;
                    src_next      = down_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                    pend_dst_next = down_reg ? src_reg + 1'b1 : src_reg - 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = fill_reg ? S_FILL : S_DONE;
                end
            end
            S_FILL:
            begin
                // The new value lands at the requested position.
                mem_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A configuration write empties the list.
        if (cfg_write)
        begin
            unique case (cfg_index)
                oal_pkg::CFG_BASE_OFFSET:
                begin
                    base_next  = cfg_data;
                    start_next = (cfg_data > cap_reg) ? cap_reg : cfg_data;
                end
                oal_pkg::CFG_CAPACITY:
                begin
                    cap_next   = cfg_cap_eff;
                    start_next = (base_reg > cfg_cap_eff) ? cfg_cap_eff : base_reg;
                end
            endcase
            count_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= oal_pkg::BASE_OFFSET_RESET;
            count_reg     <= '0;
            base_reg      <= oal_pkg::BASE_OFFSET_RESET;
            cap_reg       <= (oal_pkg::CAPACITY_RESET > CAP_LIM_V) ? CAP_LIM_V
                                                                  : oal_pkg::CAPACITY_RESET;
            left_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            cap_reg       <= cap_next;
            left_reg      <= left_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg <= action;
            pos_reg <= position;
            din_reg <= data_in;
        end
        src_reg      <= src_next;
        down_reg     <= down_next;
        fill_reg     <= fill_next;
        pend_dst_reg <= pend_dst_next;
        st_reg       <= st_next;
        rd_ok_reg    <= rd_ok_next;
    end

    // Element memory: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[to_addr(mem_waddr)] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[to_addr(mem_raddr)];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            read_data_reg <= rd_ok_reg ? rdata_reg : '0;
            status_reg    <= st_reg;
            occupied_reg  <= count_reg;
            first_reg     <= start_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign status         = status_reg;
    assign occupied       = occupied_reg;
    assign first_position = first_reg;

endmodule

`default_nettype wire
